// ===== rtl/gsfr_pkg.sv =====
// ============================================================================
// gsfr_pkg: shared types and constants of the gamepad serial frame receiver
// Framing bytes, header check values and the result record.
// ============================================================================
package gsfr_pkg;

    localparam int FRAME_BYTES = 8;
    localparam int BUTTON_W    = 20;

    localparam logic [7:0]  SOF_BYTE       = 8'hFD;
    localparam logic [7:0]  TYPE_MASK      = 8'hF0;
    localparam logic [7:0]  TYPE_MARK      = 8'h40;
    localparam logic [15:0] HEADER_MARK    = 16'hFD40;
    localparam logic [15:0] HEADER_MASK    = 16'hFFF0;
    localparam logic [BUTTON_W-1:0] BUTTON_MASK = 20'hFFFFF;
    localparam logic [63:0] FALLBACK_FRAME = 64'hFD40_0000_8080_8080;
    localparam logic [3:0]  FILL_MAX       = 4'd8;
    localparam logic [3:0]  FILL_HEADER    = 4'd2;
    localparam logic [7:0]  ERR_MAX        = 8'hFF;

    typedef struct packed {
        logic [63:0]         raw_frame;
        logic [BUTTON_W-1:0] buttons;
        logic [7:0]          left_x;
        logic [7:0]          left_y;
        logic [7:0]          right_x;
        logic [7:0]          right_y;
        logic [BUTTON_W-1:0] new_presses;
        logic [7:0]          error_tally;
    } frame_result_t;

endpackage

// ===== rtl/gsfr_byte_if.sv =====
// ============================================================================
// gsfr_byte_if: serial byte channel
// valid/ready channel carrying one received byte per transaction.
// ============================================================================
interface gsfr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/gsfr_frame_if.sv =====
// ============================================================================
// gsfr_frame_if: decoded frame channel
// valid/ready channel carrying one completed frame and its unpacked fields.
// ============================================================================
interface gsfr_frame_if;
    logic        valid;
    logic        ready;
    logic [63:0] raw_frame;
    logic [19:0] buttons;
    logic [7:0]  left_x;
    logic [7:0]  left_y;
    logic [7:0]  right_x;
    logic [7:0]  right_y;
    logic [19:0] new_presses;
    logic [7:0]  error_tally;

    modport source (output valid, output raw_frame, output buttons, output left_x,
                    output left_y, output right_x, output right_y,
                    output new_presses, output error_tally, input ready);
    modport sink   (input valid, input raw_frame, input buttons, input left_x,
                    input left_y, input right_x, input right_y,
                    input new_presses, input error_tally, output ready);
endinterface

// ===== rtl/gsfr_core.sv =====
// ============================================================================
// gsfr_core: deframer state and per-byte update
// Holds framing state and the frame store; processes one byte per step_en.
// ============================================================================
module gsfr_core
    import gsfr_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step_en,
    input  logic [7:0]    rx_byte,
    output logic          emit,
    output frame_result_t result
);

    logic                receiving_reg, receiving_next;
    logic                start_seen_reg, start_seen_next;
    logic [3:0]          fill_count_reg, fill_count_next;
    logic [7:0]          frame_store_reg [FRAME_BYTES];
    logic [7:0]          errors_reg, errors_next;
    logic [BUTTON_W-1:0] prior_buttons_reg, prior_buttons_next;
    logic                had_frame_reg, had_frame_next;

    logic                is_sof;
    logic                type_ok;
    logic                hdr_wr;
    logic                wr_en;
    logic                err_inc;
    logic [2:0]          wr_idx;
    logic [63:0]         frame_word;
    logic [63:0]         src_word;
    logic [BUTTON_W-1:0] btn;

    assign is_sof  = (rx_byte == SOF_BYTE);
    assign type_ok = ((rx_byte & TYPE_MASK) == TYPE_MARK);
    // entry 7 - fill_count
    assign wr_idx  = ~fill_count_reg[2:0];

    always_comb
    begin
        for (int k = 0; k < FRAME_BYTES; k++)
        begin
            frame_word[k*8 +: 8] = frame_store_reg[k];
        end
    end

    // header is always good in practice; fallback kept for a malformed store
    assign src_word = ((frame_word[63:48] & HEADER_MASK) == HEADER_MARK)
                      ? frame_word : FALLBACK_FRAME;
    assign btn      = src_word[32 +: BUTTON_W] & BUTTON_MASK;

    always_comb
    begin
        receiving_next     = receiving_reg;
        start_seen_next    = start_seen_reg;
        fill_count_next    = fill_count_reg;
        errors_next        = errors_reg;
        prior_buttons_next = prior_buttons_reg;
        had_frame_next     = had_frame_reg;
        hdr_wr             = 1'b0;
        wr_en              = 1'b0;
        err_inc            = 1'b0;
        emit               = 1'b0;

        if (step_en)
        begin
            if (start_seen_reg)
            begin
                start_seen_next = 1'b0;
                if (type_ok)
                begin
                    errors_next     = '0;
                    hdr_wr          = 1'b1;
                    fill_count_next = FILL_HEADER;
                    receiving_next  = 1'b1;
                end
                else
                begin
                    err_inc         = 1'b1;
                    fill_count_next = '0;
                    receiving_next  = 1'b0;
                end
            end
            else
            begin
                start_seen_next = is_sof;
                if (receiving_reg)
                begin
                    if (!is_sof)
                    begin
                        if (fill_count_reg >= FILL_MAX)
                        begin
                            err_inc        = 1'b1;
                            receiving_next = 1'b0;
                        end
                        else
                        begin
                            wr_en           = 1'b1;
                            fill_count_next = fill_count_reg + 4'd1;
                        end
                    end
                    else
                    begin
                        receiving_next     = 1'b0;
                        emit               = 1'b1;
                        prior_buttons_next = btn;
                        had_frame_next     = 1'b1;
                    end
                end
            end
        end

        if (err_inc && (errors_reg != ERR_MAX))
        begin
            errors_next = errors_reg + 8'd1;
        end
    end

    always_comb
    begin
        result.raw_frame   = frame_word;
        result.buttons     = btn;
        result.left_x      = src_word[7:0];
        result.left_y      = src_word[15:8];
        result.right_x     = src_word[23:16];
        result.right_y     = src_word[31:24];
        result.new_presses = had_frame_reg ? (btn & ~prior_buttons_reg) : '0;
        result.error_tally = errors_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            receiving_reg     <= 1'b0;
            start_seen_reg    <= 1'b0;
            fill_count_reg    <= '0;
            errors_reg        <= '0;
            prior_buttons_reg <= '0;
            had_frame_reg     <= 1'b0;
            for (int k = 0; k < FRAME_BYTES; k++)
            begin
                frame_store_reg[k] <= '0;
            end
        end
        else
        begin
            receiving_reg     <= receiving_next;
            start_seen_reg    <= start_seen_next;
            fill_count_reg    <= fill_count_next;
            errors_reg        <= errors_next;
            prior_buttons_reg <= prior_buttons_next;
            had_frame_reg     <= had_frame_next;
            if (hdr_wr)
            begin
                frame_store_reg[FRAME_BYTES-1] <= SOF_BYTE;
                frame_store_reg[FRAME_BYTES-2] <= rx_byte;
            end
            else if (wr_en)
            begin
                frame_store_reg[wr_idx] <= rx_byte;
            end
        end
    end

    // good type byte opens a frame with a cleared error count
    a_hdr_open: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && start_seen_reg && type_ok
        |=> receiving_reg && (fill_count_reg == FILL_HEADER) && (errors_reg == '0))
        else $error("header did not open frame");

    a_sof_top: assert property (@(posedge clk) disable iff (!rst_n)
        receiving_reg |-> (frame_store_reg[FRAME_BYTES-1] == SOF_BYTE))
        else $error("open frame without start byte on top");

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        receiving_reg |-> (fill_count_reg >= FILL_HEADER) && (fill_count_reg <= FILL_MAX))
        else $error("fill count out of range while receiving");

    a_emit_closes: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> !receiving_reg && start_seen_reg && had_frame_reg)
        else $error("frame close did not rearm start search");

endmodule

// ===== rtl/gamepad_serial_frame_receiver.sv =====
// ============================================================================
// gamepad_serial_frame_receiver: start-of-frame byte deframer
// Byte register, deframer core and a one-entry result register.
// ============================================================================
// Takes one serial byte per transaction on rx and returns one transaction on
// frame for every completed frame. A frame is 0xFD, a type byte with high
// nibble 4, then up to six payload bytes; the next 0xFD closes it and opens
// the next frame. The frame word has 0xFD in byte 7, the type in byte 6 and
// payload from byte 5 down; bytes a short frame did not write keep their
// earlier contents. Bad type bytes and a ninth frame byte count as errors
// (saturating at 255); a good type byte clears the count. new_presses gives
// the buttons that rose since the previous emitted frame, zero for the first.
// Rate: one byte per clock, sustained, as long as frame transactions are
// taken. A closing start byte waits in the byte register; its frame then
// waits in the result register. A result that is not taken holds the byte
// register, which in turn drops rx.ready once it is full.
// ============================================================================
module gamepad_serial_frame_receiver
    import gsfr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    gsfr_byte_if.sink    rx,
    gsfr_frame_if.source frame
);

    logic          s1_valid_reg;
    logic [7:0]    s1_byte_reg;
    logic          out_valid_reg;
    frame_result_t out_result_reg;

    logic          advance;
    logic          emit;
    frame_result_t core_result;

    // byte moves into the core when the result slot is free or draining
    assign advance  = s1_valid_reg && (!out_valid_reg || frame.ready);
    assign rx.ready = !s1_valid_reg || advance;

    gsfr_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .rx_byte (s1_byte_reg),
        .emit    (emit),
        .result  (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rx.ready)
            begin
                s1_valid_reg <= rx.valid;
            end
            if (!out_valid_reg || frame.ready)
            begin
                out_valid_reg <= emit;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            s1_byte_reg <= rx.rx_byte;
        end
        if (emit)
        begin
            out_result_reg <= core_result;
        end
    end

    assign frame.valid       = out_valid_reg;
    assign frame.raw_frame   = out_result_reg.raw_frame;
    assign frame.buttons     = out_result_reg.buttons;
    assign frame.left_x      = out_result_reg.left_x;
    assign frame.left_y      = out_result_reg.left_y;
    assign frame.right_x     = out_result_reg.right_x;
    assign frame.right_y     = out_result_reg.right_y;
    assign frame.new_presses = out_result_reg.new_presses;
    assign frame.error_tally = out_result_reg.error_tally;

    // an accepted byte always lands in the byte register
    a_byte_lands: assert property (@(posedge clk) disable iff (!rst_n)
        rx.valid && rx.ready |=> s1_valid_reg)
        else $error("accepted byte lost");

    // a stalled byte stays put
    a_byte_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg && $stable(s1_byte_reg))
        else $error("stalled byte changed");

    // a new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> !out_valid_reg || frame.ready)
        else $error("result overwritten");

endmodule

// ===== sim/gsfr_frame_checker.sv =====
// ============================================================================
// gsfr_frame_checker: frame predictor and result checker
// Watches both channels, predicts each frame from the accepted bytes and
// compares the frame transactions in order, field by field.
// ============================================================================
module gsfr_frame_checker
    import gsfr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    gsfr_byte_if  rx,
    gsfr_frame_if frame,
    output int    mismatches,
    output int    frames_pending
);

    // Predictor state
    logic                receiving;
    logic                start_seen;
    logic [3:0]          fill_count;
    logic [7:0]          frame_bytes [FRAME_BYTES];
    logic [7:0]          error_count;
    logic [BUTTON_W-1:0] last_buttons;
    logic                had_frame;

    frame_result_t       due_frames [$];
    int                  frames_seen;

    function automatic logic [7:0] bump_errors(input logic [7:0] n);
        return (n == ERR_MAX) ? n : n + 8'd1;
    endfunction

    task automatic note_failure(input string what);
        mismatches++;
        if (mismatches <= 10)
            $display("%s", what);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
            note_failure($sformatf("frame %0d: %s expected %h, got %h",
                                   frames_seen, name, want, got));
    endtask

    // One byte through the deframer; a closing start byte queues a frame.
    task automatic deframe_byte(input logic [7:0] b);
        logic [63:0]   word;
        logic [63:0]   src;
        frame_result_t r;
        if (start_seen)
        begin
            start_seen = 1'b0;
            fill_count = '0;
            if ((b & TYPE_MASK) == TYPE_MARK)
            begin
                error_count = '0;
                frame_bytes[FRAME_BYTES-1] = SOF_BYTE;
                frame_bytes[FRAME_BYTES-2] = b;
                fill_count = FILL_HEADER;
                receiving = 1'b1;
            end
            else
            begin
                error_count = bump_errors(error_count);
                receiving = 1'b0;
            end
        end
        else
        begin
            start_seen = (b == SOF_BYTE);
            if (receiving && b != SOF_BYTE)
            begin
                if (fill_count >= FILL_MAX)
                begin
                    error_count = bump_errors(error_count);
                    receiving = 1'b0;
                end
                else
                begin
                    // entry 7 - fill_count
                    frame_bytes[~fill_count[2:0]] = b;
                    fill_count = fill_count + 4'd1;
                end
            end
            else if (receiving)
            begin
                receiving = 1'b0;
                word = '0;
                for (int k = FRAME_BYTES - 1; k >= 0; k--)
                    word = {word[55:0], frame_bytes[k]};
                src = word;
                if ((src[63:48] & HEADER_MASK) != HEADER_MARK)
                    src = FALLBACK_FRAME;
                r.raw_frame   = word;
                r.buttons     = src[51:32];
                r.left_x      = src[7:0];
                r.left_y      = src[15:8];
                r.right_x     = src[23:16];
                r.right_y     = src[31:24];
                r.new_presses = had_frame ? (r.buttons & ~last_buttons) : '0;
                r.error_tally = error_count;
                last_buttons  = r.buttons;
                had_frame     = 1'b1;
                due_frames.push_back(r);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        frame_result_t want;
        if (!rst_n)
        begin
            receiving      = 1'b0;
            start_seen     = 1'b0;
            fill_count     = '0;
            error_count    = '0;
            last_buttons   = '0;
            had_frame      = 1'b0;
            for (int k = 0; k < FRAME_BYTES; k++)
                frame_bytes[k] = '0;
            due_frames.delete();
            frames_seen    = 0;
            mismatches     = 0;
            frames_pending = 0;
        end
        else
        begin
            // results first: anything arriving now was predicted earlier
            if (frame.valid && frame.ready)
            begin
                if (due_frames.size() == 0)
                begin
                    note_failure($sformatf("frame %0d: unexpected, raw_frame %h",
                                           frames_seen, frame.raw_frame));
                end
                else
                begin
                    want = due_frames.pop_front();
                    check_field("raw_frame", want.raw_frame, frame.raw_frame);
                    check_field("buttons", 64'(want.buttons), 64'(frame.buttons));
                    check_field("left_x", 64'(want.left_x), 64'(frame.left_x));
                    check_field("left_y", 64'(want.left_y), 64'(frame.left_y));
                    check_field("right_x", 64'(want.right_x), 64'(frame.right_x));
                    check_field("right_y", 64'(want.right_y), 64'(frame.right_y));
                    check_field("new_presses", 64'(want.new_presses),
                                64'(frame.new_presses));
                    check_field("error_tally", 64'(want.error_tally),
                                64'(frame.error_tally));
                end
                frames_seen++;
            end
            if (rx.valid && rx.ready)
                deframe_byte(rx.rx_byte);
            frames_pending = due_frames.size();
        end
    end

endmodule

// ===== sim/tb_top.sv =====
// ============================================================================
// tb_top: gamepad serial frame receiver testbench
// Drives byte streams through the deframer under bursty input and a stalling
// frame receiver; the checker beside the block predicts and compares.
// ============================================================================
module tb_top;
    import gsfr_pkg::*;

    localparam int RANDOM_ITEMS     = 400;
    localparam int SATURATE_HEADERS = 260;  // enough bad headers to pin the count
    localparam int SETTLE_CYCLES    = 10;
    localparam int CYCLE_LIMIT      = 200000;

    // Frame receiver behavior, picked anew at random by the ready driver
    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_COIN,
        READY_SPARSE,
        READY_LONG_STALL
    } ready_mode_t;

    logic        clk;
    logic        rst_n;
    int          mismatches;
    int          frames_pending;
    int          cycles;
    int          bytes_sent;
    int          random_start;
    int          burst_left;
    int          stall_tick;
    bit          steady;        // no sender gaps while set
    bit          drained_mid;
    ready_mode_t stall_mode;

    // Opening sequence: full frame (first frame, no presses), a short frame
    // that leaves stale bytes, a rising-edge frame, a bad type, a start byte
    // as type, then a good header with seven payload bytes (overflow).
    logic [7:0] opening [28] = '{
        8'hFF,                                      // noise while searching
        8'hFD, 8'h4F, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF,
        8'hFD, 8'h40, 8'h00,                        // closes full frame
        8'hFD, 8'h4A, 8'hF0,                        // closes short frame
        8'hFD, 8'h3F,                               // closes frame, bad type
        8'hFD, 8'hFD,                               // start byte as type
        8'hFD, 8'h41, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'h77
    };

    gsfr_byte_if  rx_if ();
    gsfr_frame_if frame_if ();

    gamepad_serial_frame_receiver u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_if),
        .frame (frame_if)
    );

    gsfr_frame_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .rx             (rx_if),
        .frame          (frame_if),
        .mismatches     (mismatches),
        .frames_pending (frames_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Hard stop in case the block hangs
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    // Frame receiver: ready changes at the falling edge, pattern per mode.
    // Long-stall mode holds ready low except at the end of each repeating window.
    initial
    begin
        frame_if.ready = 1'b0;
        stall_mode     = READY_ALWAYS;
        forever
        begin
            @(negedge clk);
            if (stall_tick % 64 == 0)
                stall_mode = ready_mode_t'($urandom_range(0, 3));
            stall_tick++;
            case (stall_mode)
                READY_ALWAYS: frame_if.ready <= 1'b1;
                READY_COIN:   frame_if.ready <= ($urandom_range(0, 1) == 1);
                READY_SPARSE: frame_if.ready <= (stall_tick % 4 == 0);
                default:      frame_if.ready <= (stall_tick % 24 >= 20);
            endcase
        end
    end

    function automatic logic [7:0] good_type();
        return TYPE_MARK | 8'($urandom_range(0, 15));
    endfunction

    // Any type byte whose high nibble is not the mark
    function automatic logic [7:0] bad_type();
        logic [7:0] t;
        t = 8'($urandom_range(0, 255));
        if ((t & TYPE_MASK) == TYPE_MARK)
            t = t ^ 8'h80;
        return t;
    endfunction

    // One byte transaction. Valid is set at the falling edge, once per step;
    // between bursts the sender drops valid for a random gap, none while steady.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap = steady ? 0 : $urandom_range(0, 6);
            if (gap != 0)
            begin
                rx_if.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do
            @(posedge clk);
        while (!rx_if.ready);
        burst_left--;
        bytes_sent++;
    endtask

    // Sender holds off until every predicted frame has been taken
    task automatic wait_for_drain();
        @(negedge clk);
        rx_if.valid <= 1'b0;
        while (frames_pending != 0)
            @(negedge clk);
    endtask

    // Mostly well-formed frames with random content; the rest is overflow,
    // bad headers and loose noise. A sequence that opens with a start byte
    // closes the frame left open by the one before it.
    task automatic send_random_sequence();
        int         pick;
        int         len;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 7) == 0)
            steady = !steady;
        if (pick < 70)
        begin
            send_byte(SOF_BYTE);
            send_byte(good_type());
            len = ($urandom_range(0, 2) == 0) ? 6 : $urandom_range(0, 6);
            repeat (len) send_byte(8'($urandom_range(0, 255)));
        end
        else if (pick < 80)
        begin
            // too many payload bytes; keep them clear of the start byte
            send_byte(SOF_BYTE);
            send_byte(good_type());
            len = $urandom_range(7, 9);
            repeat (len)
            begin
                b = 8'($urandom_range(0, 255));
                if (b == SOF_BYTE)
                    b = 8'h00;
                send_byte(b);
            end
        end
        else if (pick < 90)
        begin
            send_byte(SOF_BYTE);
            send_byte(bad_type());
        end
        else
        begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = 8'h00;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (opening[i])
            send_byte(opening[i]);
        wait_for_drain();

        // Error count saturation: a long run of bad headers, nothing emitted
        for (int i = 0; i < SATURATE_HEADERS; i++)
        begin
            send_byte(SOF_BYTE);
            send_byte(bad_type());
        end

        random_start = bytes_sent;
        while (bytes_sent - random_start < RANDOM_ITEMS)
        begin
            send_random_sequence();
            if (!drained_mid && bytes_sent - random_start >= RANDOM_ITEMS / 2)
            begin
                wait_for_drain();
                drained_mid = 1'b1;
            end
        end

        // Close the last open frame so its result is checked too
        send_byte(SOF_BYTE);
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0 && frames_pending == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
